FILE: sv/lsra_pkg.sv
// Package for the linear scan register allocator.
// Constants, payload structs and config register indexes; no dependencies.
package lsra_pkg;
   localparam int NUM_REGS  = 16;
   localparam int MAX_LIVE  = 256;
   localparam int MAX_VREGS = 1024;
   localparam int LIVE_W    = $clog2(MAX_LIVE);
   localparam int CNT_W     = LIVE_W + 1;
   localparam int REG_W     = 4;
   localparam int CSR_W     = 64;

   localparam logic [1:0] CSR_CALLER_ORDER = 2'd0;
   localparam logic [1:0] CSR_CALLER_COUNT = 2'd1;
   localparam logic [1:0] CSR_CALLEE_ORDER = 2'd2;
   localparam logic [1:0] CSR_CALLEE_COUNT = 2'd3;

   typedef struct packed {
      logic [9:0]  vreg_id;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic        crosses_call;
   } req_type;

   typedef struct packed {
      logic [9:0]  assigned_vreg;
      logic        in_register;
      logic [9:0]  location;
      logic        last_result;
      logic        table_full;
      logic [10:0] spill_slots_used;
      logic [15:0] callee_saved_mask;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  vreg;
      logic [15:0] end_pos;
      logic        in_reg;
      logic [9:0]  loc;
   } entry_type;
endpackage

FILE: sv/lsra_ram.sv
// Simple one-write one-read RAM with registered read data.
// Generic; no package dependency.
module lsra_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/linear_scan_register_allocator.sv
// Linear scan register allocator: one live interval per item.
// Each active table entry is handled by a read, a wait and an update on one
// port, in the expiry pass and in the victim search.
// One item at a time; ready is low while an item is in work or results wait.
// Synchronous active-high reset clears counts, used mask and config and marks
// every register free; tables need no clearing.
module linear_scan_register_allocator
   import lsra_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_EXP_RD, ST_EXP_WT, ST_EXP_DO, ST_LIST, ST_VIC_RD, ST_VIC_WT,
      ST_VIC_DO, ST_VIC_CHK, ST_SLOT_RD, ST_SLOT_WT, ST_FINISH, ST_OUT1, ST_OUT2
   } state_type;

   state_type         state_ff, state_in;
   logic [63:0]       caller_ord_ff, callee_ord_ff;
   logic [4:0]        caller_cnt_ff, callee_cnt_ff;
   logic [15:0]       free_ff, free_in, used_ff, used_in;
   logic [CNT_W-1:0]  act_cnt_ff, act_cnt_in, fs_cnt_ff, fs_cnt_in;
   logic [10:0]       next_ff, next_in;
   req_type           cur_ff, cur_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, wr_ff, wr_in;
   logic [4:0]        li_ff, li_in;
   logic              phase_ff, phase_in;
   logic              got_ff, got_in;
   logic [3:0]        reg_ff, reg_in;
   logic [LIVE_W-1:0] vic_ff, vic_in;
   entry_type         vic_e_ff, vic_e_in;
   logic              steal_ff, steal_in;
   logic [9:0]        slot_ff, slot_in;
   rsp_type           out1_ff, out1_in, out2_ff, out2_in;
   logic              rv_ff, rv_in;

   logic              at_we, fs_we;
   logic [LIVE_W-1:0] at_wa, at_ra, fs_wa, fs_ra;
   entry_type         at_wd, at_rd;
   logic [9:0]        fs_wd, fs_rd;

   lsra_ram #(.DEPTH(MAX_LIVE), .WIDTH($bits(entry_type))) u_act (
      .clock(clock), .wr_en(at_we), .wr_addr(at_wa), .wr_data(at_wd),
      .rd_addr(at_ra), .rd_data(at_rd));
   lsra_ram #(.DEPTH(MAX_LIVE), .WIDTH(10)) u_fslot (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_rd));

   logic [3:0]  lreg;
   logic [4:0]  llen;
   logic [63:0] lord;
   logic        in_callee;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = out1_ff;

   always_comb begin
      in_callee = 1'b0;
      for (int i = 0; i < 16; i++)
         if (5'(i) < callee_cnt_ff && callee_ord_ff[4*i +: 4] == vic_e_ff.loc[3:0]
             && vic_e_ff.loc[9:4] == '0)
            in_callee = 1'b1;
   end

   always_comb begin
      state_in = state_ff; free_in = free_ff; used_in = used_ff;
      act_cnt_in = act_cnt_ff; fs_cnt_in = fs_cnt_ff; next_in = next_ff;
      cur_in = cur_ff; idx_in = idx_ff; wr_in = wr_ff; li_in = li_ff;
      phase_in = phase_ff; got_in = got_ff; reg_in = reg_ff; vic_in = vic_ff;
      vic_e_in = vic_e_ff; steal_in = steal_ff; slot_in = slot_ff;
      out1_in = out1_ff; out2_in = out2_ff; rv_in = rv_ff;
      at_we = 1'b0; at_wa = wr_ff[LIVE_W-1:0]; at_wd = at_rd;
      at_ra = idx_ff[LIVE_W-1:0];
      fs_we = 1'b0; fs_wa = fs_cnt_ff[LIVE_W-1:0]; fs_wd = at_rd.loc;
      fs_ra = LIVE_W'(fs_cnt_ff - 1'b1);
      lord = phase_ff ? callee_ord_ff : caller_ord_ff;
      llen = phase_ff ? callee_cnt_ff : caller_cnt_ff;
      if (llen > 5'd16) llen = 5'd16;
      lreg = lord[4*li_ff[3:0] +: 4];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_data; idx_in = '0; wr_in = '0;
               state_in = ST_EXP_RD;
            end
         end
         ST_EXP_RD: begin
            if (idx_ff == act_cnt_ff) begin
               act_cnt_in = wr_ff;
               li_in = '0; got_in = 1'b0; phase_in = cur_ff.crosses_call;
               if (wr_ff == CNT_W'(MAX_LIVE)) begin
                  out1_in = '{cur_ff.vreg_id, 1'b0, 10'd0, 1'b1, 1'b1,
                              next_ff, used_ff};
                  rv_in = 1'b1; state_in = ST_OUT1;
               end else state_in = ST_LIST;
            end else state_in = ST_EXP_WT;
         end
         ST_EXP_WT: state_in = ST_EXP_DO;
         ST_EXP_DO: begin
            if (at_rd.end_pos >= cur_ff.start_pos) begin
               at_we = 1'b1; wr_in = wr_ff + 1'b1;
            end else if (at_rd.in_reg) begin
               if (at_rd.loc[9:4] == '0) free_in[at_rd.loc[3:0]] = 1'b1;
            end else if (fs_cnt_ff < CNT_W'(MAX_LIVE)) begin
               fs_we = 1'b1; fs_cnt_in = fs_cnt_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1; state_in = ST_EXP_RD;
         end
         ST_LIST: begin
            if (li_ff < llen) begin
               if (free_ff[lreg]) begin
                  free_in[lreg] = 1'b0; got_in = 1'b1; reg_in = lreg;
                  if (phase_ff) used_in[lreg] = 1'b1;
                  state_in = ST_FINISH;
               end
               li_in = li_ff + 1'b1;
            end else if (!phase_ff) begin
               phase_in = 1'b1; li_in = '0;
            end else begin
               idx_in = '0; vic_in = '0; steal_in = 1'b0;
               state_in = (act_cnt_ff == '0) ? ST_SLOT_RD : ST_VIC_RD;
            end
         end
         ST_VIC_RD: begin
            if (idx_ff == act_cnt_ff) begin
               at_ra = vic_ff; state_in = ST_VIC_CHK;
            end else state_in = ST_VIC_WT;
         end
         ST_VIC_WT: state_in = ST_VIC_DO;
         ST_VIC_DO: begin
            if (idx_ff == '0 || at_rd.end_pos > vic_e_ff.end_pos) begin
               vic_e_in = at_rd; vic_in = idx_ff[LIVE_W-1:0];
            end
            idx_in = idx_ff + 1'b1; state_in = ST_VIC_RD;
         end
         ST_VIC_CHK: begin
            steal_in = vic_e_ff.end_pos > cur_ff.end_pos && vic_e_ff.in_reg &&
                       (!cur_ff.crosses_call || in_callee);
            state_in = ST_SLOT_RD;
         end
         ST_SLOT_RD: state_in = ST_SLOT_WT;
         ST_SLOT_WT: begin
            if (fs_cnt_ff != '0) begin
               slot_in = fs_rd; fs_cnt_in = fs_cnt_ff - 1'b1;
            end else if (next_ff < 11'd1024) begin
               slot_in = next_ff[9:0]; next_in = next_ff + 1'b1;
            end else slot_in = 10'd1023;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            at_we = 1'b1; at_wa = act_cnt_ff[LIVE_W-1:0];
            act_cnt_in = act_cnt_ff + 1'b1;
            rv_in = 1'b1; state_in = ST_OUT1;
            if (got_ff) begin
               at_wd = '{cur_ff.vreg_id, cur_ff.end_pos, 1'b1, {6'd0, reg_ff}};
               out1_in = '{cur_ff.vreg_id, 1'b1, {6'd0, reg_ff}, 1'b1, 1'b0,
                           next_ff, used_ff};
            end else if (steal_ff) begin
               at_wd = '{cur_ff.vreg_id, cur_ff.end_pos, 1'b1, vic_e_ff.loc};
               out1_in = '{vic_e_ff.vreg, 1'b0, slot_ff, 1'b0, 1'b0,
                           next_ff, used_ff};
               out2_in = '{cur_ff.vreg_id, 1'b1, vic_e_ff.loc, 1'b1, 1'b0,
                           next_ff, used_ff};
               got_in = 1'b1; state_in = ST_OUT2;
            end else begin
               at_wd = '{cur_ff.vreg_id, cur_ff.end_pos, 1'b0, slot_ff};
               out1_in = '{cur_ff.vreg_id, 1'b0, slot_ff, 1'b1, 1'b0,
                           next_ff, used_ff};
            end
         end
         ST_OUT2: begin
            // victim rewrite shares the port; done while first result waits
            if (got_ff) begin
               at_we = 1'b1; at_wa = vic_ff;
               at_wd = '{vic_e_ff.vreg, vic_e_ff.end_pos, 1'b0, slot_ff};
               got_in = 1'b0;
            end
            if (rsp_ready) begin
               out1_in = out2_ff; state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (rsp_ready) begin
               rv_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; free_ff <= '1; used_ff <= '0; act_cnt_ff <= '0;
         fs_cnt_ff <= '0; next_ff <= '0; rv_ff <= 1'b0;
         caller_ord_ff <= '0; callee_ord_ff <= '0;
         caller_cnt_ff <= '0; callee_cnt_ff <= '0;
      end else begin
         state_ff <= state_in; free_ff <= free_in; used_ff <= used_in;
         act_cnt_ff <= act_cnt_in; fs_cnt_ff <= fs_cnt_in; next_ff <= next_in;
         rv_ff <= rv_in;
         if (csr_write) begin
            case (csr_index)
               CSR_CALLER_ORDER: caller_ord_ff <= csr_wdata;
               CSR_CALLER_COUNT: caller_cnt_ff <= csr_wdata[4:0];
               CSR_CALLEE_ORDER: callee_ord_ff <= csr_wdata;
               CSR_CALLEE_COUNT: callee_cnt_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
      cur_ff <= cur_in; idx_ff <= idx_in; wr_ff <= wr_in; li_ff <= li_in;
      phase_ff <= phase_in; got_ff <= got_in; reg_ff <= reg_in;
      vic_ff <= vic_in; vic_e_ff <= vic_e_in; steal_ff <= steal_in;
      slot_ff <= slot_in; out1_ff <= out1_in; out2_ff <= out2_in;
   end
endmodule
